FILE: src/calendar_clock_counter_top_macros.svh
// assertion macros for the calendar clock counter
`ifndef CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH
`define CALENDAR_CLOCK_COUNTER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CALCC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CALCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/calcc_pkg.sv
// shared types, constants and helpers of the calendar clock counter
`default_nettype none

package calcc_pkg;

    // opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // configuration register indexes
    localparam logic CFG_VALID_YEAR   = 1'b0;
    localparam logic CFG_SECONDS_STEP = 1'b1;

    // calendar limits
    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int MONTH_LAST    = 12;
    localparam int MONTH_FEB     = 2;
    localparam int DAY_LONG_LAST = 31;
    localparam int DAY_FEB_LAST  = 28;
    localparam int WEEKDAY_LAST  = 7;

    // reset values
    localparam logic [15:0] RST_YEAR    = 16'd2022;
    localparam logic [5:0]  RST_STEP    = 6'd10;
    localparam logic [3:0]  RST_MONTH   = 4'd1;
    localparam logic [4:0]  RST_DAY     = 5'd1;
    localparam logic [2:0]  RST_WEEKDAY = 3'd1;
    localparam logic [15:0] RST_WEEK    = 16'd1;

    // full clock state
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [15:0] week;
    } clock_t;

    // one input beat
    typedef struct packed {
        logic        opcode;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [15:0] week;
    } item_t;

    // april, june, september, november
    function automatic logic is_thirty_day(input logic [3:0] m);
        return m inside {4'd4, 4'd6, 4'd9, 4'd11};
    endfunction

endpackage

`default_nettype wire

FILE: src/calcc_step.sv
// next clock state for one tick or set beat
`default_nettype none

module calcc_step
    import calcc_pkg::*;
(
    input  wire item_t       item,
    input  wire clock_t      cur,
    input  wire logic [15:0] valid_year,
    input  wire logic [5:0]  seconds_step,
    output clock_t           nxt,
    output logic             accepted
);

    logic [6:0] sec_sum;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;
    logic       sec_carry;
    logic       min_carry;
    logic       hour_carry;
    logic [4:0] day_inc;
    logic       leap;
    logic       month_end;
    logic [3:0] month_inc;
    logic       date_ok;
    logic       time_ok;
    clock_t     tick_clk;
    clock_t     set_clk;

    // seconds, minutes and hours carry chain
    always_comb
    begin
        sec_sum    = {1'b0, cur.second} + {1'b0, seconds_step};
        sec_carry  = (sec_sum >= 7'(SEC_PER_MIN));
        min_inc    = cur.minute + 6'd1;
        min_carry  = sec_carry && (min_inc >= 6'(MIN_PER_HOUR));
        hour_inc   = cur.hour + 5'd1;
        hour_carry = min_carry && (hour_inc >= 5'(HOUR_PER_DAY));
    end

    // day, month and year rollover
    always_comb
    begin
        leap      = (cur.year[1:0] == 2'd0);
        day_inc   = cur.day + 5'd1;
        month_end = (day_inc == 5'd0)
                 || (day_inc == 5'(DAY_LONG_LAST) && is_thirty_day(cur.month))
                 || (cur.month == 4'(MONTH_FEB)
                     && ((day_inc == 5'd30 && leap) || (day_inc == 5'd29 && !leap)));
        month_inc = cur.month + 4'd1;
    end

    // tick result
    always_comb
    begin
        tick_clk = cur;
        if (!sec_carry)
        begin
            tick_clk.second = sec_sum[5:0];
        end
        else
        begin
            tick_clk.second = 6'd0;
            tick_clk.minute = min_inc;
            if (min_carry)
            begin
                tick_clk.minute = 6'd0;
                tick_clk.hour   = hour_inc;
            end
            if (hour_carry)
            begin
                tick_clk.hour = 5'd0;
                tick_clk.day  = day_inc;
                if (month_end)
                begin
                    tick_clk.day   = 5'd1;
                    tick_clk.month = month_inc;
                    if (month_inc == 4'(MONTH_LAST + 1))
                    begin
                        tick_clk.month = 4'd1;
                        tick_clk.year  = cur.year + 16'd1;
                    end
                end
                if (cur.weekday == 3'(WEEKDAY_LAST))
                begin
                    tick_clk.weekday = 3'd1;
                    tick_clk.week    = cur.week + 16'd1;
                end
                else
                begin
                    tick_clk.weekday = cur.weekday + 3'd1;
                end
            end
        end
    end

    // set validation and partial load
    always_comb
    begin
        date_ok = (item.year == valid_year)
               && (item.day != 5'd0)
               && (item.month >= 4'd1) && (item.month <= 4'(MONTH_LAST))
               && !(item.day == 5'(DAY_LONG_LAST)
                    && (item.month == 4'(MONTH_FEB) || is_thirty_day(item.month)))
               && !(item.month == 4'(MONTH_FEB) && item.day > 5'(DAY_FEB_LAST));
        time_ok = (item.hour <= 5'(HOUR_PER_DAY - 1))
               && (item.minute <= 6'(MIN_PER_HOUR - 1))
               && (item.second <= 6'(SEC_PER_MIN - 1));
        set_clk         = cur;
        set_clk.weekday = item.weekday;
        set_clk.week    = item.week;
        if (date_ok)
        begin
            set_clk.year  = item.year;
            set_clk.month = item.month;
            set_clk.day   = item.day;
            if (time_ok)
            begin
                set_clk.hour   = item.hour;
                set_clk.minute = item.minute;
                set_clk.second = item.second;
            end
        end
    end

    // pick by opcode
    always_comb
    begin
        case (item.opcode)
            OP_SET:
            begin
                nxt      = set_clk;
                accepted = date_ok && time_ok;
            end
            default:
            begin
                nxt      = tick_clk;
                accepted = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/calendar_clock_counter_top.sv
// calendar clock counter top level: input stage, clock state and result
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_ready   | opcode, set_year .. set_week
//   out     | out       | out_valid / out_ready | accepted, cur_year .. cur_week
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one beat per cycle sustained while out_ready holds; a result passes through the
// input register, then the clock state register that drives the result ports.
// the carry chain from seconds to year is evaluated combinationally by calcc_step.
// reset puts the clock at 2022-01-01 00:00:00, weekday 1, week 1, step 10.
// an output stall holds the clock state; the input register still takes one beat.
// cfg is always ready; the user must write it only while the block is idle, as the block does not enforce this.
`default_nettype none

`include "calendar_clock_counter_top_macros.svh"

module calendar_clock_counter_top
    import calcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [15:0] set_year,
    input  wire logic [3:0]  set_month,
    input  wire logic [4:0]  set_day,
    input  wire logic [4:0]  set_hour,
    input  wire logic [5:0]  set_minute,
    input  wire logic [5:0]  set_second,
    input  wire logic [2:0]  set_weekday,
    input  wire logic [15:0] set_week,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic [15:0]      cur_year,
    output logic [3:0]       cur_month,
    output logic [4:0]       cur_day,
    output logic [4:0]       cur_hour,
    output logic [5:0]       cur_minute,
    output logic [5:0]       cur_second,
    output logic [2:0]       cur_weekday,
    output logic [15:0]      cur_week,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg;
    item_t       item_reg;
    clock_t      clock_reg;
    clock_t      clock_next;
    logic        accepted_reg;
    logic        accepted_next;
    logic        out_valid_reg;
    logic [15:0] valid_year_reg;
    logic [5:0]  seconds_step_reg;
    logic        step_fire;

    // handshake control
    assign step_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || step_fire;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_year_reg   <= RST_YEAR;
            seconds_step_reg <= RST_STEP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VALID_YEAR:   valid_year_reg   <= cfg_data;
                CFG_SECONDS_STEP: seconds_step_reg <= cfg_data[5:0];
                default:          valid_year_reg   <= valid_year_reg;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{opcode:  opcode,
                          year:    set_year,
                          month:   set_month,
                          day:     set_day,
                          hour:    set_hour,
                          minute:  set_minute,
                          second:  set_second,
                          weekday: set_weekday,
                          week:    set_week};
        end
    end

    // next clock state
    calcc_step u_step (
        .item         (item_reg),
        .cur          (clock_reg),
        .valid_year   (valid_year_reg),
        .seconds_step (seconds_step_reg),
        .nxt          (clock_next),
        .accepted     (accepted_next)
    );

    // clock state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg     <= '{year:    RST_YEAR,
                               month:   RST_MONTH,
                               day:     RST_DAY,
                               hour:    5'd0,
                               minute:  6'd0,
                               second:  6'd0,
                               weekday: RST_WEEKDAY,
                               week:    RST_WEEK};
            accepted_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            clock_reg     <= clock_next;
            accepted_reg  <= accepted_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result ports
    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign cur_year    = clock_reg.year;
    assign cur_month   = clock_reg.month;
    assign cur_day     = clock_reg.day;
    assign cur_hour    = clock_reg.hour;
    assign cur_minute  = clock_reg.minute;
    assign cur_second  = clock_reg.second;
    assign cur_weekday = clock_reg.weekday;
    assign cur_week    = clock_reg.week;

    // checks
    `CALCC_ASSERT_NEXT(a_fire_gives_result, step_fire, out_valid_reg,
        "processed beat did not produce a result")
    `CALCC_ASSERT_NEXT(a_state_holds, !step_fire,
        $stable(clock_reg) && $stable(accepted_reg),
        "clock state changed without a processed beat")
    `CALCC_ASSERT_NEXT(a_input_holds, in_valid_reg && !step_fire, in_valid_reg,
        "input stage dropped a waiting beat")
    `CALCC_ASSERT_IMPLY(a_time_range, 1'b1,
        clock_reg.second < 6'(SEC_PER_MIN) && clock_reg.minute < 6'(MIN_PER_HOUR)
        && clock_reg.hour < 5'(HOUR_PER_DAY),
        "time of day out of range")
    `CALCC_ASSERT_IMPLY(a_month_range, 1'b1,
        clock_reg.month >= 4'd1 && clock_reg.month <= 4'(MONTH_LAST),
        "month out of range")

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// calendar clock counter testbench: clock scoreboard, beat drivers and run sequence

import calcc_pkg::*;

// keeps its own calendar and compares every result beat against it
class clock_scoreboard;

    typedef struct {
        logic   ok;
        clock_t c;
    } reading_t;

    clock_t      now;
    logic [15:0] year_cfg;
    logic [5:0]  step_cfg;
    reading_t    pending[$];

    int errors;
    int reports;
    int checked;
    int n_ticks;
    int n_loaded;
    int n_partial;
    int n_refused;
    int n_day_rolls;
    int n_year_rolls;

    function new();
        year_cfg    = 16'd2022;
        step_cfg    = 6'd10;
        now.year    = 16'd2022;
        now.month   = 4'd1;
        now.day     = 5'd1;
        now.hour    = 5'd0;
        now.minute  = 6'd0;
        now.second  = 6'd0;
        now.weekday = 3'd1;
        now.week    = 16'd1;
    endfunction

    function void set_register(input logic idx, input logic [15:0] value);
        if (idx == CFG_VALID_YEAR)
        begin
            year_cfg = value;
        end
        else
        begin
            step_cfg = value[5:0];
        end
    endfunction

    function bit thirty_day_month(input logic [3:0] m);
        return m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11;
    endfunction

    function void bump_month();
        now.month = now.month + 4'd1;
        if (now.month == 4'd13)
        begin
            now.month = 4'd1;
            now.year  = now.year + 16'd1;
            n_year_rolls++;
        end
    endfunction

    // predict the clock after one accepted input beat
    function void note_beat(input item_t it);
        reading_t r;
        logic [6:0] sum;
        logic leap;
        r.ok = 1'b1;
        if (it.opcode == OP_SET)
        begin
            // day of week and week count load on every set
            now.weekday = it.weekday;
            now.week    = it.week;
            r.ok = 1'b0;
            if (it.year == year_cfg && it.day != 5'd0 && it.month >= 4'd1 && it.month <= 4'd12
                && !(it.day == 5'd31 && (it.month == 4'd2 || thirty_day_month(it.month)))
                && !(it.month == 4'd2 && it.day > 5'd28))
            begin
                now.year  = it.year;
                now.month = it.month;
                now.day   = it.day;
                if (it.hour <= 5'd23 && it.minute <= 6'd59 && it.second <= 6'd59)
                begin
                    now.hour   = it.hour;
                    now.minute = it.minute;
                    now.second = it.second;
                    r.ok = 1'b1;
                    n_loaded++;
                end
                else
                begin
                    n_partial++;
                end
            end
            else
            begin
                n_refused++;
            end
        end
        else
        begin
            n_ticks++;
            sum = {1'b0, now.second} + {1'b0, step_cfg};
            if (sum < 7'd60)
            begin
                now.second = sum[5:0];
            end
            else
            begin
                // overflow drops any excess seconds
                now.second = 6'd0;
                now.minute = now.minute + 6'd1;
                if (now.minute >= 6'd60)
                begin
                    now.minute = 6'd0;
                    now.hour   = now.hour + 5'd1;
                    if (now.hour >= 5'd24)
                    begin
                        now.hour = 5'd0;
                        leap = (now.year[1:0] == 2'b00);
                        now.day = now.day + 5'd1;
                        n_day_rolls++;
                        if (now.day == 5'd0)
                        begin
                            now.day = 5'd1;
                            bump_month();
                        end
                        else if (now.day == 5'd31 && thirty_day_month(now.month))
                        begin
                            now.day = 5'd1;
                            bump_month();
                        end
                        else if (now.month == 4'd2 && ((now.day == 5'd30 && leap)
                                 || (now.day == 5'd29 && !leap)))
                        begin
                            now.day = 5'd1;
                            bump_month();
                        end
                        // weekday wraps 7 to 1 and carries into the week count
                        if (now.weekday == 3'd7)
                        begin
                            now.weekday = 3'd1;
                            now.week    = now.week + 16'd1;
                        end
                        else
                        begin
                            now.weekday = now.weekday + 3'd1;
                        end
                    end
                end
            end
        end
        r.c = now;
        pending.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            if (reports < 40)
            begin
                $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            end
            reports++;
        end
    endfunction

    // compare one result beat with the oldest prediction
    function void check_reading(input logic ok, input clock_t got);
        reading_t want;
        if (pending.size() == 0)
        begin
            errors++;
            if (reports < 40)
            begin
                $display("%0t ns: result beat with none expected, actual accepted %0d year %0d",
                         $time, ok, got.year);
            end
            reports++;
            return;
        end
        want = pending.pop_front();
        checked++;
        compare_field("accepted", want.ok, ok);
        compare_field("cur_year", want.c.year, got.year);
        compare_field("cur_month", want.c.month, got.month);
        compare_field("cur_day", want.c.day, got.day);
        compare_field("cur_hour", want.c.hour, got.hour);
        compare_field("cur_minute", want.c.minute, got.minute);
        compare_field("cur_second", want.c.second, got.second);
        compare_field("cur_weekday", want.c.weekday, got.weekday);
        compare_field("cur_week", want.c.week, got.week);
    endfunction

endclass

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    item_t       in_item = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'd0;

    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic        accepted;
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [2:0]  cur_weekday;
    logic [15:0] cur_week;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;

    clock_scoreboard sb = new();

    calendar_clock_counter_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (in_item.opcode),
        .set_year    (in_item.year),
        .set_month   (in_item.month),
        .set_day     (in_item.day),
        .set_hour    (in_item.hour),
        .set_minute  (in_item.minute),
        .set_second  (in_item.second),
        .set_weekday (in_item.weekday),
        .set_week    (in_item.week),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .cur_year    (cur_year),
        .cur_month   (cur_month),
        .cur_day     (cur_day),
        .cur_hour    (cur_hour),
        .cur_minute  (cur_minute),
        .cur_second  (cur_second),
        .cur_weekday (cur_weekday),
        .cur_week    (cur_week),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side ready: long hold when asked, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result beat monitor
    always @(posedge clk)
    begin : watch_results
        clock_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
                     cur_weekday, cur_week};
            sb.check_reading(accepted, seen);
        end
    end

    function automatic logic [4:0] days_in(input logic [3:0] m);
        case (m)
            4'd2:                      return 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

    function automatic item_t set_beat(input logic [15:0] y, input logic [3:0] m,
                                       input logic [4:0] d, input logic [4:0] h,
                                       input logic [5:0] mi, input logic [5:0] s,
                                       input logic [2:0] wd, input logic [15:0] wk);
        item_t it;
        it.opcode  = OP_SET;
        it.year    = y;
        it.month   = m;
        it.day     = d;
        it.hour    = h;
        it.minute  = mi;
        it.second  = s;
        it.weekday = wd;
        it.week    = wk;
        return it;
    endfunction

    function automatic item_t random_beat();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[61:0];
    endfunction

    // tick with random content in the ignored fields
    function automatic item_t tick_beat();
        item_t it;
        it = random_beat();
        it.opcode = OP_TICK;
        return it;
    endfunction

    // valid set, biased toward month ends and the last seconds of the day
    function automatic item_t valid_set_beat(input logic [15:0] y, input logic [5:0] step);
        logic [3:0]  m;
        logic [4:0]  last;
        logic [4:0]  d;
        logic [4:0]  h;
        logic [5:0]  mi;
        logic [5:0]  s;
        logic [2:0]  wd;
        logic [15:0] wk;
        m    = 4'($urandom_range(12, 1));
        last = days_in(m);
        d    = ($urandom_range(1) == 0) ? last : 5'($urandom_range(last, 1));
        h    = ($urandom_range(3) != 0) ? 5'd23 : 5'($urandom_range(23));
        mi   = ($urandom_range(3) != 0) ? 6'd59 : 6'($urandom_range(59));
        s    = ($urandom_range(1) == 0) ? 6'($urandom_range(59, 60 - step))
                                        : 6'($urandom_range(59));
        wd   = ($urandom_range(15) == 0) ? 3'd0 : 3'($urandom_range(7, 1));
        wk   = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
        return set_beat(y, m, d, h, mi, s, wd, wk);
    endfunction

    // valid set with one field pushed out of range
    function automatic item_t broken_set_beat(input logic [15:0] y, input logic [5:0] step);
        item_t it;
        it = valid_set_beat(y, step);
        case ($urandom_range(6))
            0: it.year = y ^ 16'($urandom_range(65535, 1));
            1: it.month = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
            2: it.day = 5'd0;
            3:
            begin
                case ($urandom_range(4))
                    0:       it.month = 4'd2;
                    1:       it.month = 4'd4;
                    2:       it.month = 4'd6;
                    3:       it.month = 4'd9;
                    default: it.month = 4'd11;
                endcase
                it.day = 5'($urandom_range(31, days_in(it.month) + 1));
            end
            4: it.hour = 5'($urandom_range(31, 24));
            5: it.minute = 6'($urandom_range(63, 60));
            default: it.second = 6'($urandom_range(63, 60));
        endcase
        return it;
    endfunction

    // offer one beat after a random gap and wait for it to be taken
    task automatic send_beat(input item_t it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_beat(it);
    endtask

    // stop offering and wait until every result has arrived
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] year, input logic [5:0] step);
        write_reg(CFG_VALID_YEAR, year);
        write_reg(CFG_SECONDS_STEP, {10'd0, step});
    endtask

    task automatic set_pace(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // mostly valid sets followed by tick bursts, some broken sets and noise
    task automatic random_phase(input int n_beats, input int hold_at);
        int sent;
        int pick;
        int burst;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < n_beats)
        begin
            if (!held && hold_at > 0 && sent >= hold_at)
            begin
                hold_left = HOLD_CYCLES;
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                send_beat(valid_set_beat(sb.year_cfg, sb.step_cfg));
                burst = $urandom_range(12, 1);
            end
            else if (pick < 85)
            begin
                send_beat(broken_set_beat(sb.year_cfg, sb.step_cfg));
                burst = $urandom_range(3);
            end
            else
            begin
                send_beat(random_beat());
                burst = 0;
            end
            sent = sent + 1 + burst;
            repeat (burst) send_beat(tick_beat());
        end
        drain();
    endtask

    initial
    begin : run
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: year 2022, step 10
        set_pace(0, 0);
        send_beat(tick_beat());
        send_beat(set_beat(16'd2022, 4'd12, 5'd31, 5'd23, 6'd59, 6'd50, 3'd7, 16'hFFFF));
        send_beat(tick_beat());
        send_beat(set_beat(16'd2021, 4'd6, 5'd15, 5'd10, 6'd10, 6'd10, 3'd3, 16'd5));
        send_beat(set_beat(16'd2022, 4'd0, 5'd10, 5'd1, 6'd1, 6'd1, 3'd2, 16'd6));
        send_beat(set_beat(16'd2022, 4'd13, 5'd10, 5'd1, 6'd1, 6'd1, 3'd2, 16'd6));
        send_beat(set_beat(16'd2022, 4'd15, 5'd31, 5'd1, 6'd1, 6'd1, 3'd2, 16'd6));
        send_beat(set_beat(16'd2022, 4'd2, 5'd29, 5'd1, 6'd1, 6'd1, 3'd4, 16'd7));
        send_beat(set_beat(16'd2022, 4'd2, 5'd31, 5'd1, 6'd1, 6'd1, 3'd4, 16'd7));
        send_beat(set_beat(16'd2022, 4'd4, 5'd31, 5'd1, 6'd1, 6'd1, 3'd4, 16'd7));
        send_beat(set_beat(16'd2022, 4'd5, 5'd0, 5'd1, 6'd1, 6'd1, 3'd4, 16'd7));
        // date loads, time refused
        send_beat(set_beat(16'd2022, 4'd1, 5'd31, 5'd24, 6'd0, 6'd0, 3'd0, 16'd8));
        send_beat(set_beat(16'd2022, 4'd1, 5'd31, 5'd23, 6'd60, 6'd0, 3'd0, 16'd8));
        send_beat(set_beat(16'd2022, 4'd1, 5'd31, 5'd23, 6'd59, 6'd63, 3'd0, 16'd8));
        // weekday zero and excess seconds dropped on overflow
        send_beat(set_beat(16'd2022, 4'd1, 5'd31, 5'd23, 6'd59, 6'd59, 3'd0, 16'd0));
        send_beat(tick_beat());
        // thirty-day month end
        send_beat(set_beat(16'd2022, 4'd4, 5'd30, 5'd23, 6'd59, 6'd50, 3'd6, 16'd9));
        send_beat(tick_beat());
        // february end, common year
        send_beat(set_beat(16'd2022, 4'd2, 5'd28, 5'd23, 6'd59, 6'd55, 3'd5, 16'd9));
        send_beat(tick_beat());
        send_beat(set_beat(16'd2022, 4'd11, 5'd30, 5'd23, 6'd59, 6'd50, 3'd1, 16'd9));
        send_beat(tick_beat());
        send_beat(set_beat(16'd2022, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd1, 16'd1));
        send_beat(set_beat(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 3'd7, 16'hFFFF));
        send_beat(tick_beat());
        drain();

        // leap year, step 59: february 28 rolls into the 29th
        configure(16'd2024, 6'd59);
        send_beat(set_beat(16'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd7, 16'hFFFF));
        repeat (4) send_beat(tick_beat());
        drain();

        // year zero, step 1
        configure(16'd0, 6'd1);
        send_beat(set_beat(16'd0, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd3, 16'd100));
        send_beat(tick_beat());
        send_beat(set_beat(16'd0, 4'd3, 5'd31, 5'd23, 6'd59, 6'd58, 3'd3, 16'd100));
        send_beat(tick_beat());
        send_beat(tick_beat());
        send_beat(set_beat(16'd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd7, 16'd100));
        send_beat(tick_beat());
        drain();

        // top year: wraps to zero
        configure(16'hFFFF, 6'd30);
        send_beat(set_beat(16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd30, 3'd7, 16'hFFFF));
        send_beat(tick_beat());
        send_beat(set_beat(16'hFFFF, 4'd2, 5'd28, 5'd23, 6'd59, 6'd30, 3'd2, 16'd3));
        send_beat(tick_beat());
        drain();

        // random traffic under the four pacing modes
        configure(16'd2024, 6'd59);
        set_pace(0, 0);
        random_phase(300, 100);

        configure(16'($urandom), 6'd1);
        set_pace(84, 0);
        random_phase(300, 0);

        configure(16'd2022, 6'($urandom_range(58, 2)));
        set_pace(0, 84);
        random_phase(300, 0);

        configure(16'd0, 6'd30);
        set_pace(8, 8);
        random_phase(300, 0);

        // let any stray result show up
        repeat (8) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0d results never arrived", sb.pending.size());
            sb.errors += sb.pending.size();
        end

        $display("checked %0d results: %0d ticks, %0d full sets, %0d date-only, %0d refused",
                 sb.checked, sb.n_ticks, sb.n_loaded, sb.n_partial, sb.n_refused);
        $display("%0d day rollovers and %0d year rollovers across 8 register settings",
                 sb.n_day_rolls, sb.n_year_rolls);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
